@@ sv/lpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar packet parser package
// Shared constants, the job word passed from the parser to the point unit,
// and the quarter-wave sine function.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int SineFracBitsDefault = 14;
    localparam logic [13:0] MaxRangeReset = 14'd3000;
    localparam logic [7:0] StartByte = 8'hFA;
    localparam logic [7:0] IndexLow = 8'hA0;
    localparam logic [7:0] IndexHigh = 8'hF9;

    // One checked packet: the four readings and what the points share.
    typedef struct packed {
        logic [6:0]       pkt_index;
        logic [15:0]      speed;
        logic [3:0][13:0] distances;
        logic [3:0]       keep;
    } job_t;

    // Sine of deg (0..90) with frac fraction bits, built with a fixed-point
    // Taylor series, worked out at elaboration.
    function automatic logic [20:0] quarter_sine(input int deg, input int frac);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int d;
        int divs [6];
        begin
            divs = '{156, 110, 72, 42, 20, 6};
            d = (deg > 90) ? 90 : deg;
            x = (64'(d) * 64'hC90FDAA2) / 64'd180;
            x2 = (x * x) >> 30;
            t = 64'd1 << 30;
            for (int k = 0; k < 6; k++) begin
                t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(divs[k]);
            end
            s = (x * t) >> 30;
            quarter_sine = 21'((s + (64'd1 << (29 - frac))) >> (30 - frac));
        end
    endfunction

endpackage

@@ sv/lpp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar packet byte parser
// Hunts for packets, gathers the body, checks the checksum and pushes one
// job per good packet with at least one kept reading into a two-entry queue.
// ----------------------------------------------------------------------------
module lpp_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic [13:0]     max_range,
    output logic            job_valid,
    input  logic            job_ready,
    output lpp_pkg::job_t   job
);

    logic [4:0]       pos_reg, pos_next;
    logic [6:0]       idx_reg;
    logic [7:0]       low_reg;
    logic [26:0]      acc_reg;
    logic [15:0]      speed_reg;
    logic [3:0][13:0] dist_reg;
    logic [3:0]       inv_reg;

    lpp_pkg::job_t q_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;

    logic        take;
    logic [15:0] word;
    logic [26:0] acc_step;
    logic [14:0] folded;
    logic        push, pop;
    logic [1:0]  slot;
    lpp_pkg::job_t new_job;

    // A good packet may need a queue slot, so bytes are held while it is full.
    assign s_ready = (cnt_reg != 2'd2);
    assign take = s_valid && s_ready;
    assign word = {s_rx_byte, low_reg};
    assign acc_step = {acc_reg[25:0], 1'b0} + 27'(word);
    assign folded = 15'({1'b0, acc_reg[14:0]} + {4'd0, acc_reg[26:15]});
    assign slot = 2'((pos_reg - 5'd5) >> 2);

    always_comb begin
        new_job.pkt_index = idx_reg;
        new_job.speed = speed_reg;
        new_job.distances = dist_reg;
        for (int i = 0; i < 4; i++) begin
            new_job.keep[i] = !inv_reg[i] && (dist_reg[i] <= max_range);
        end
    end

    assign push = take && (pos_reg == 5'd21) && (word == {1'b0, folded}) && (|new_job.keep);
    assign pop = job_valid && job_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rd_ptr_reg];

    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            if (pos_reg == 5'd0) begin
                pos_next = (s_rx_byte == lpp_pkg::StartByte) ? 5'd1 : 5'd0;
            end else if (pos_reg == 5'd1) begin
                pos_next = (s_rx_byte >= lpp_pkg::IndexLow && s_rx_byte <= lpp_pkg::IndexHigh)
                           ? 5'd2 : 5'd0;
            end else if (pos_reg >= 5'd21) begin
                pos_next = 5'd0;
            end else begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 5'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            pos_reg <= pos_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= new_job;
        if (take) begin
            if (pos_reg == 5'd1) begin
                idx_reg <= 7'(s_rx_byte - lpp_pkg::IndexLow);
                acc_reg <= {11'd0, s_rx_byte, lpp_pkg::StartByte};
            end else if (pos_reg >= 5'd2 && pos_reg < 5'd21) begin
                if (!pos_reg[0]) begin
                    low_reg <= s_rx_byte;
                end else begin
                    acc_reg <= acc_step;
                    if (pos_reg == 5'd3) speed_reg <= word;
                    if (pos_reg >= 5'd5 && pos_reg[1:0] == 2'd1) begin
                        dist_reg[slot] <= {s_rx_byte[5:0], low_reg};
                        inv_reg[slot] <= s_rx_byte[7];
                    end
                end
            end else if (pos_reg == 5'd21) begin
                low_reg <= low_reg;
            end
        end
    end

endmodule

@@ sv/lpp_points.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar point generator
// Walks the kept readings of one job, one per cycle while the output is free,
// multiplies by sine and cosine and holds the result in an output register.
// ----------------------------------------------------------------------------
module lpp_points #(
    parameter int SINE_FRACTION_BITS = lpp_pkg::SineFracBitsDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  lpp_pkg::job_t        job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [14:0]   m_point_x,
    output logic signed [14:0]   m_point_y,
    output logic [8:0]           m_angle_deg,
    output logic [13:0]          m_distance,
    output logic [15:0]          m_spin_speed,
    output logic                 m_last
);

    localparam int SW = SINE_FRACTION_BITS + 1;
    localparam int PW = 14 + SW;

    logic [3:0]    done_reg, done_next;
    logic [3:0]    rem;
    logic [1:0]    slot;
    logic          last_one;
    logic          adv;
    logic [8:0]    angle;
    logic [8:0]    qa;
    logic [1:0]    quad;
    logic [6:0]    r;
    logic [SW-1:0] sin_mag, cos_mag;
    logic [PW-1:0] py, px;
    logic [14:0]   ym, xm;

    function automatic logic [SW-1:0] sine_of(input logic [6:0] d);
        logic [SW-1:0] v;
        begin
            v = '0;
            for (int i = 0; i <= 90; i++) begin
                if (d == 7'(i)) v = SW'(lpp_pkg::quarter_sine(i, SINE_FRACTION_BITS));
            end
            sine_of = v;
        end
    endfunction

    assign rem = job.keep & ~done_reg;
    always_comb begin
        slot = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (rem[i]) slot = 2'(i);
        end
    end
    assign done_next = done_reg | (4'd1 << slot);
    assign last_one = ((job.keep & ~done_next) == 4'd0);
    assign adv = job_valid && (!m_valid || m_ready);
    assign job_ready = adv && last_one;

    assign angle = 9'({job.pkt_index, 2'b00}) + 9'(slot);
    always_comb begin
        if (angle >= 9'd270) begin
            quad = 2'd3; qa = angle - 9'd270;
        end else if (angle >= 9'd180) begin
            quad = 2'd2; qa = angle - 9'd180;
        end else if (angle >= 9'd90) begin
            quad = 2'd1; qa = angle - 9'd90;
        end else begin
            quad = 2'd0; qa = angle;
        end
    end
    assign r = qa[6:0];
    // Even quadrants read sine at r and cosine at 90 - r; odd ones swap.
    assign sin_mag = quad[0] ? sine_of(7'd90 - r) : sine_of(r);
    assign cos_mag = quad[0] ? sine_of(r) : sine_of(7'd90 - r);
    assign py = PW'(job.distances[slot]) * PW'(sin_mag);
    assign px = PW'(job.distances[slot]) * PW'(cos_mag);
    assign ym = 15'(py >> SINE_FRACTION_BITS);
    assign xm = 15'(px >> SINE_FRACTION_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 4'd0;
            m_valid <= 1'b0;
        end else begin
            if (adv) begin
                done_reg <= last_one ? 4'd0 : done_next;
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // Cosine is negative in the second and third quadrants.
            m_point_y <= quad[1] ? -$signed(ym) : $signed(ym);
            m_point_x <= (quad == 2'd1 || quad == 2'd2) ? -$signed(xm) : $signed(xm);
            m_angle_deg <= angle;
            m_distance <= job.distances[slot];
            m_spin_speed <= job.speed;
            m_last <= last_one;
        end
    end

endmodule

@@ sv/lidar_packet_to_points.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar packet to points
// Parses the rotating lidar byte stream and emits Cartesian points.
// ----------------------------------------------------------------------------
// Bytes arrive on the s_ channel, one byte per accepted valid/ready cycle.
// Each 22-byte packet with a good checksum yields one point per reading that
// is flagged valid and lies within max_range, on the m_ channel, in slot
// order, with m_last set on the final point of the packet.
// Bytes are taken every cycle while the two-entry job queue has room; the
// point unit turns one kept reading into a point per cycle while the output
// is free or being taken; a packet's job is written into the queue when its
// final byte is taken, and each point is then held in the output register.
// The user must write max_range via cfg_we/cfg_wdata only while the block
// is idle; the block does not enforce this. A synchronous active-low reset
// returns the parser to hunting for the start byte, empties the queue and
// drops any pending point; max_range returns to 3000. On a receiver stall,
// the output register holds its point, the queue fills and s_ready falls.
// ----------------------------------------------------------------------------
module lidar_packet_to_points #(
    parameter int SINE_FRACTION_BITS = lpp_pkg::SineFracBitsDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [13:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [14:0]  m_point_x,
    output logic signed [14:0]  m_point_y,
    output logic [8:0]          m_angle_deg,
    output logic [13:0]         m_distance,
    output logic [15:0]         m_spin_speed,
    output logic                m_last
);

    logic [13:0]   max_range_reg;
    logic          job_valid, job_ready;
    lpp_pkg::job_t job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= lpp_pkg::MaxRangeReset;
        end else if (cfg_we) begin
            max_range_reg <= cfg_wdata;
        end
    end

    lpp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .max_range (max_range_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    lpp_points #(
        .SINE_FRACTION_BITS (SINE_FRACTION_BITS)
    ) u_points (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_angle_deg  (m_angle_deg),
        .m_distance   (m_distance),
        .m_spin_speed (m_spin_speed),
        .m_last       (m_last)
    );

endmodule
